FILE: src/dpb_pkg.sv
// Shared types and constants for the depth pixel back-projection block.
package dpb_pkg;

	localparam int COORD_BITS = 12;
	localparam int DEPTH_W    = 16;
	localparam int CFG_W      = 16;
	localparam int COLOR_W    = 8;
	localparam int OUT_W      = 32;
	localparam int MAG_W      = (COORD_BITS + 4 > CFG_W) ? COORD_BITS + 4 : CFG_W;

	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_FOCAL_X     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd4;

	localparam logic [CFG_W-1:0] FOCAL_X_RST     = 16'd8400;
	localparam logic [CFG_W-1:0] FOCAL_Y_RST     = 16'd8400;
	localparam logic [CFG_W-1:0] CENTER_X_RST    = 16'd5120;
	localparam logic [CFG_W-1:0] CENTER_Y_RST    = 16'd3840;
	localparam logic [CFG_W-1:0] DEPTH_SCALE_RST = 16'd5000;

	localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] SAT_U   = {OUT_W{1'b1}};

	typedef struct packed {
		logic [COORD_BITS-1:0] column;
		logic [COORD_BITS-1:0] row;
		logic [DEPTH_W-1:0]    depth_raw;
		logic [COLOR_W-1:0]    red;
		logic [COLOR_W-1:0]    green;
		logic [COLOR_W-1:0]    blue;
	} pix_in_t;

	typedef struct packed {
		logic                     point_valid;
		logic signed [OUT_W-1:0]  x_m;
		logic signed [OUT_W-1:0]  y_m;
		logic [OUT_W-1:0]         z_m;
		logic [COLOR_W-1:0]       red_out;
		logic [COLOR_W-1:0]       green_out;
		logic [COLOR_W-1:0]       blue_out;
	} point_out_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} color_t;

	typedef struct packed {
		logic   nz;
		logic   neg_x;
		logic   neg_y;
		color_t color;
	} side_t;

endpackage

FILE: src/dpb_div.sv
// Pipelined restoring divider with one quotient bit per stage and overflow detection.
module dpb_div #(
	parameter int NUM_W = 44,
	parameter int DEN_W = 32,
	parameter int Q_W   = 32
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);

	localparam int UP_W  = NUM_W - Q_W;
	localparam int CMP_W = (UP_W > DEN_W) ? UP_W : DEN_W;

	logic [CMP_W-1:0] up_ext;
	logic [CMP_W-1:0] den_ext;

	logic [DEN_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0]   low_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W+1];
	logic             ovf_s [Q_W+1];

	logic [DEN_W:0] trial [Q_W];
	logic [DEN_W:0] diff  [Q_W];
	logic           ge    [Q_W];

	assign up_ext  = CMP_W'(num[NUM_W-1:Q_W]);
	assign den_ext = CMP_W'(den);

	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			trial[k] = {rem_s[k], low_s[k][Q_W-1]};
			diff[k]  = trial[k] - {1'b0, den_s[k]};
			ge[k]    = trial[k] >= {1'b0, den_s[k]};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= up_ext[DEN_W-1:0];
		low_s[0] <= num[Q_W-1:0];
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= up_ext >= den_ext;
		for (int k = 1; k <= Q_W; k++) begin
			quo_s[k] <= {quo_s[k-1][Q_W-2:0], ge[k-1]};
			ovf_s[k] <= ovf_s[k-1];
		end
		for (int k = 1; k < Q_W; k++) begin
			rem_s[k] <= ge[k-1] ? diff[k-1][DEN_W-1:0] : trial[k-1][DEN_W-1:0];
			low_s[k] <= {low_s[k-1][Q_W-2:0], 1'b0};
			den_s[k] <= den_s[k-1];
		end
	end

	assign quo = quo_s[Q_W];
	assign ovf = ovf_s[Q_W];

endmodule

FILE: src/depth_pixel_backprojection.sv
// Top level of the pinhole depth back-projection pipeline with its APB register file.
// A transaction accepted at a rising edge passes through stage 1, stage 2, the divider
// pipeline and the output register; done and the result ports then show its result.
// Throughput: one transaction per cycle; busy stays low and the pipeline never stalls.
// The latency is set by the three one-bit-per-stage dividers.
// Reset clears the valid bits and loads the registers with their defaults.
module depth_pixel_backprojection #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  dpb_pkg::pix_in_t                    pixel,
	output logic                                done,
	output dpb_pkg::point_out_t                 point,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dpb_pkg::PADDR_W-1:0]         paddr,
	input  logic [dpb_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [dpb_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int MAG_W   = dpb_pkg::MAG_W;
	localparam int CFG_W   = dpb_pkg::CFG_W;
	localparam int DEPTH_W = dpb_pkg::DEPTH_W;
	localparam int OUT_W   = dpb_pkg::OUT_W;
	localparam int APB_W   = dpb_pkg::APB_DATA_W;
	localparam int PROD_W  = MAG_W + DEPTH_W;
	localparam int NUMX_W  = PROD_W + FRAC_BITS;
	localparam int DENX_W  = 2 * CFG_W;
	localparam int NUMZ_W  = OUT_W + DEPTH_W;
	localparam int DIV_LAT = OUT_W + 1;

	logic [CFG_W-1:0] focal_x_q;
	logic [CFG_W-1:0] focal_y_q;
	logic [CFG_W-1:0] center_x_q;
	logic [CFG_W-1:0] center_y_q;
	logic [CFG_W-1:0] depth_scale_q;

	logic [dpb_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;

	assign reg_idx = paddr[dpb_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign busy    = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q     <= dpb_pkg::FOCAL_X_RST;
			focal_y_q     <= dpb_pkg::FOCAL_Y_RST;
			center_x_q    <= dpb_pkg::CENTER_X_RST;
			center_y_q    <= dpb_pkg::CENTER_Y_RST;
			depth_scale_q <= dpb_pkg::DEPTH_SCALE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				dpb_pkg::REG_FOCAL_X:     focal_x_q     <= pwdata[CFG_W-1:0];
				dpb_pkg::REG_FOCAL_Y:     focal_y_q     <= pwdata[CFG_W-1:0];
				dpb_pkg::REG_CENTER_X:    center_x_q    <= pwdata[CFG_W-1:0];
				dpb_pkg::REG_CENTER_Y:    center_y_q    <= pwdata[CFG_W-1:0];
				dpb_pkg::REG_DEPTH_SCALE: depth_scale_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dpb_pkg::REG_FOCAL_X:     prdata = APB_W'(focal_x_q);
			dpb_pkg::REG_FOCAL_Y:     prdata = APB_W'(focal_y_q);
			dpb_pkg::REG_CENTER_X:    prdata = APB_W'(center_x_q);
			dpb_pkg::REG_CENTER_Y:    prdata = APB_W'(center_y_q);
			dpb_pkg::REG_DEPTH_SCALE: prdata = APB_W'(depth_scale_q);
			default:                  prdata = '0;
		endcase
	end

	// Stage 1: offsets from the principal point and effective divisors.
	logic [MAG_W-1:0] px_ext;
	logic [MAG_W-1:0] py_ext;
	logic [MAG_W-1:0] cx_ext;
	logic [MAG_W-1:0] cy_ext;
	logic             neg_x;
	logic             neg_y;

	assign px_ext = MAG_W'({pixel.column, 4'b0000});
	assign py_ext = MAG_W'({pixel.row, 4'b0000});
	assign cx_ext = MAG_W'(center_x_q);
	assign cy_ext = MAG_W'(center_y_q);
	assign neg_x  = px_ext < cx_ext;
	assign neg_y  = py_ext < cy_ext;

	logic                v_s1;
	dpb_pkg::side_t      side_s1;
	logic [MAG_W-1:0]    mag_x_s1;
	logic [MAG_W-1:0]    mag_y_s1;
	logic [DEPTH_W-1:0]  raw_s1;
	logic [CFG_W-1:0]    scale_s1;
	logic [CFG_W-1:0]    fx_s1;
	logic [CFG_W-1:0]    fy_s1;

	always_ff @(posedge clk) begin
		side_s1.nz          <= pixel.depth_raw != '0;
		side_s1.neg_x       <= neg_x;
		side_s1.neg_y       <= neg_y;
		side_s1.color.red   <= pixel.red;
		side_s1.color.green <= pixel.green;
		side_s1.color.blue  <= pixel.blue;
		mag_x_s1            <= neg_x ? cx_ext - px_ext : px_ext - cx_ext;
		mag_y_s1            <= neg_y ? cy_ext - py_ext : py_ext - cy_ext;
		raw_s1              <= pixel.depth_raw;
		scale_s1            <= (depth_scale_q == '0) ? CFG_W'(1) : depth_scale_q;
		fx_s1               <= (focal_x_q == '0) ? CFG_W'(1) : focal_x_q;
		fy_s1               <= (focal_y_q == '0) ? CFG_W'(1) : focal_y_q;
	end

	// Stage 2: numerator and denominator products.
	logic                v_s2;
	dpb_pkg::side_t      side_s2;
	logic [PROD_W-1:0]   prod_x_s2;
	logic [PROD_W-1:0]   prod_y_s2;
	logic [DENX_W-1:0]   den_x_s2;
	logic [DENX_W-1:0]   den_y_s2;
	logic [DEPTH_W-1:0]  raw_s2;
	logic [CFG_W-1:0]    scale_s2;

	always_ff @(posedge clk) begin
		side_s2   <= side_s1;
		prod_x_s2 <= PROD_W'(mag_x_s1) * PROD_W'(raw_s1);
		prod_y_s2 <= PROD_W'(mag_y_s1) * PROD_W'(raw_s1);
		den_x_s2  <= DENX_W'(fx_s1) * DENX_W'(scale_s1);
		den_y_s2  <= DENX_W'(fy_s1) * DENX_W'(scale_s1);
		raw_s2    <= raw_s1;
		scale_s2  <= scale_s1;
	end

	// Divider stages.
	logic [NUMX_W-1:0] num_x;
	logic [NUMX_W-1:0] num_y;
	logic [NUMZ_W-1:0] num_z;
	logic [OUT_W-1:0]  q_x;
	logic [OUT_W-1:0]  q_y;
	logic [OUT_W-1:0]  q_z;
	logic              ovf_x;
	logic              ovf_y;
	logic              ovf_z;

	assign num_x = {prod_x_s2, {FRAC_BITS{1'b0}}};
	assign num_y = {prod_y_s2, {FRAC_BITS{1'b0}}};
	assign num_z = NUMZ_W'(raw_s2) << FRAC_BITS;

	dpb_div #(.NUM_W(NUMX_W), .DEN_W(DENX_W), .Q_W(OUT_W)) u_div_x (
		.clk (clk),
		.num (num_x),
		.den (den_x_s2),
		.quo (q_x),
		.ovf (ovf_x)
	);

	dpb_div #(.NUM_W(NUMX_W), .DEN_W(DENX_W), .Q_W(OUT_W)) u_div_y (
		.clk (clk),
		.num (num_y),
		.den (den_y_s2),
		.quo (q_y),
		.ovf (ovf_y)
	);

	dpb_div #(.NUM_W(NUMZ_W), .DEN_W(CFG_W), .Q_W(OUT_W)) u_div_z (
		.clk (clk),
		.num (num_z),
		.den (scale_s2),
		.quo (q_z),
		.ovf (ovf_z)
	);

	logic           v_sd    [DIV_LAT];
	dpb_pkg::side_t side_sd [DIV_LAT];

	always_ff @(posedge clk) begin
		side_sd[0] <= side_s2;
		for (int k = 1; k < DIV_LAT; k++) begin
			side_sd[k] <= side_sd[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) begin
				v_sd[k] <= 1'b0;
			end
		end else begin
			v_s1    <= start && !busy;
			v_s2    <= v_s1;
			v_sd[0] <= v_s2;
			for (int k = 1; k < DIV_LAT; k++) begin
				v_sd[k] <= v_sd[k-1];
			end
		end
	end

	// Output stage: sign, saturation and the zero-depth case.
	dpb_pkg::side_t      side_end;
	dpb_pkg::point_out_t point_d;
	dpb_pkg::point_out_t point_q;
	logic                done_q;

	assign side_end = side_sd[DIV_LAT-1];

	always_comb begin
		point_d.point_valid = side_end.nz;
		point_d.red_out     = side_end.color.red;
		point_d.green_out   = side_end.color.green;
		point_d.blue_out    = side_end.color.blue;
		if (!side_end.nz) begin
			point_d.x_m = '0;
			point_d.y_m = '0;
			point_d.z_m = '0;
		end else begin
			if (side_end.neg_x) begin
				point_d.x_m = (ovf_x || q_x[OUT_W-1]) ? dpb_pkg::SAT_NEG : '0 - q_x;
			end else begin
				point_d.x_m = (ovf_x || q_x[OUT_W-1]) ? dpb_pkg::SAT_POS : q_x;
			end
			if (side_end.neg_y) begin
				point_d.y_m = (ovf_y || q_y[OUT_W-1]) ? dpb_pkg::SAT_NEG : '0 - q_y;
			end else begin
				point_d.y_m = (ovf_y || q_y[OUT_W-1]) ? dpb_pkg::SAT_POS : q_y;
			end
			point_d.z_m = ovf_z ? dpb_pkg::SAT_U : q_z;
		end
	end

	always_ff @(posedge clk) begin
		point_q <= point_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_sd[DIV_LAT-1];
		end
	end

	assign done  = done_q;
	assign point = point_q;

endmodule
